FILE: rtl/fipc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the sine table generator for the inverse
// Park/Clarke PWM block. No dependencies.
package fipc_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int SINE_Q = 1 << SINE_TABLE_BITS;
	localparam int ROM_AW = SINE_TABLE_BITS + 1;
	localparam int DIV_STAGES = 16;
	localparam int PROD_W = 47;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic signed [51:0] SQRT3_Q16 = 52'sd113512;

	// configuration register indexes
	localparam logic [2:0] REG_SUPPLY = 3'd0;
	localparam logic [2:0] REG_PERIOD = 3'd1;
	localparam logic [2:0] REG_POLES = 3'd2;
	localparam logic [2:0] REG_DIR = 3'd3;
	localparam logic [2:0] REG_ZERO = 3'd4;

	// angle operation codes
	localparam logic OP_ELECTRICAL = 1'b0;
	localparam logic OP_MECHANICAL = 1'b1;

	typedef struct packed {
		logic operation;
		logic signed [15:0] torque_voltage;
		logic [15:0] rotor_angle;
	} cmd_word_t;

	typedef struct packed {
		logic [15:0] electrical_angle;
		logic [15:0] phase_a_volts;
		logic [15:0] phase_b_volts;
		logic [15:0] phase_c_volts;
		logic [15:0] duty_a;
		logic [15:0] duty_b;
		logic [15:0] duty_c;
	} res_word_t;

	// Quarter-wave sine entry in Q15, integer Taylor series in Q30
	function automatic logic [14:0] sine_entry(input int unsigned k);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] r;
		x = (HALF_PI_Q30 * 64'(k)) >> SINE_TABLE_BITS;
		x2 = (x * x) >> 30;
		term = x;
		pos = '0;
		neg = '0;
		for (int n = 0; n < 10; n++) begin
			if (n % 2 == 1) neg = neg + term;
			else pos = pos + term;
			term = ((term * x2) >> 30) / 64'((2 * n + 2) * (2 * n + 3));
		end
		r = (pos > neg) ? (pos - neg) : 64'd0;
		r = (r + 64'd16384) >> 15;
		if (r > 64'd32767) r = 64'd32767;
		return r[14:0];
	endfunction

endpackage

FILE: rtl/fipc_sine_rom.sv
`timescale 1ns / 1ps
// Quarter-wave sine ROM with two registered read ports (sine and cosine).
// Depends on fipc_pkg.
module fipc_sine_rom import fipc_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [ROM_AW-1:0] addr_sin,
	input  logic [ROM_AW-1:0] addr_cos,
	output logic [14:0]       data_sin,
	output logic [14:0]       data_cos
);

	logic [14:0] rom [0:SINE_Q];

	// fill table from constants at elaboration
	for (genvar k = 0; k <= SINE_Q; k++) begin : g_rom
		assign rom[k] = sine_entry(k);
	end

	// read both ports, hold on stall
	always_ff @(posedge clk) begin
		if (en) begin
			data_sin <= rom[addr_sin];
			data_cos <= rom[addr_cos];
		end
	end

endmodule

FILE: rtl/fipc_duty_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, for compare counts.
// Depends on fipc_pkg.
module fipc_duty_div import fipc_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [PROD_W-1:0] dividend,
	input  logic [30:0]       divisor,
	output logic [15:0]       quotient
);

	logic [PROD_W-1:0] rem_s [0:DIV_STAGES];
	logic [15:0]       quo_s [0:DIV_STAGES];

	assign rem_s[0] = dividend;
	assign quo_s[0] = '0;

	// resolve one quotient bit per stage, top bit first
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		localparam int B = DIV_STAGES - 1 - j;
		logic [PROD_W-1:0] shd;
		assign shd = PROD_W'(divisor) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_s[j] >= shd) begin
					rem_s[j+1] <= rem_s[j] - shd;
					quo_s[j+1] <= quo_s[j] | (16'd1 << B);
				end else begin
					rem_s[j+1] <= rem_s[j];
					quo_s[j+1] <= quo_s[j];
				end
			end
		end
	end

	assign quotient = quo_s[DIV_STAGES];

endmodule

FILE: rtl/foc_inverse_park_clarke_pwm.sv
`timescale 1ns / 1ps
// Six datapath stages plus a 16-stage divider lie between an accepted command
// word and its result word. Throughput: one word per cycle while no result word waits.
// The whole pipeline holds while a result word waits; no word is lost.
// Reset (arst_n low) clears all valid bits and loads the register defaults.
// Depends on fipc_pkg, fipc_sine_rom, fipc_duty_div.
module foc_inverse_park_clarke_pwm import fipc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_word_t   cmd,
	output logic        res_valid,
	input  logic        res_ready,
	output res_word_t   res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	typedef struct packed {
		logic [15:0] angle;
		logic [15:0] va;
		logic [15:0] vb;
		logic [15:0] vc;
	} side_t;

	logic [15:0] supply_q, period_q, zero_q;
	logic [6:0]  poles_q;
	logic        dir_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= 16'd12288;
			period_q <= 16'd1000;
			poles_q <= 7'd1;
			dir_q <= 1'b0;
			zero_q <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SUPPLY: supply_q <= cfg_data;
				REG_PERIOD: period_q <= cfg_data;
				REG_POLES: poles_q <= cfg_data[6:0];
				REG_DIR: dir_q <= cfg_data[0];
				REG_ZERO: zero_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [14:0] half;
	logic [30:0] full;
	logic signed [37:0] hq;
	assign half = supply_q[15:1];
	assign full = {supply_q, 15'd0};
	assign hq = $signed({8'd0, half, 15'd0});

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic vd_s [1:DIV_STAGES];

	assign en = !res_valid || res_ready;
	assign cmd_ready = en;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int i = 1; i <= DIV_STAGES; i++) vd_s[i] <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			vd_s[1] <= v_s6;
			for (int i = 2; i <= DIV_STAGES; i++) vd_s[i] <= vd_s[i-1];
		end
	end

	// stage 1: electrical angle and Uq clamp
	logic [15:0] mech;
	logic [15:0] angle_s1;
	logic signed [15:0] uq_s1;
	logic signed [16:0] half_s;
	assign half_s = $signed({2'b00, half});
	always_comb begin
		mech = 16'(poles_q * cmd.rotor_angle);
		if (dir_q) mech = 16'd0 - mech;
		mech = mech - zero_q;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			angle_s1 <= (cmd.operation == OP_MECHANICAL) ? mech : cmd.rotor_angle;
			if (17'(cmd.torque_voltage) > half_s) uq_s1 <= 16'(half_s);
			else if (17'(cmd.torque_voltage) < -half_s) uq_s1 <= 16'(-half_s);
			else uq_s1 <= cmd.torque_voltage;
		end
	end

	// stage 2: quadrant folding and table read
	logic [15:0] cos_ang;
	logic [SINE_TABLE_BITS-1:0] idx_sin, idx_cos;
	logic [ROM_AW-1:0] addr_sin, addr_cos;
	logic [14:0] tab_sin, tab_cos;
	logic [15:0] angle_s2;
	logic signed [15:0] uq_s2;
	logic neg_sin_s2, neg_cos_s2;
	assign cos_ang = angle_s1 + 16'd16384;
	assign idx_sin = SINE_TABLE_BITS'(angle_s1[13:0] >> (14 - SINE_TABLE_BITS));
	assign idx_cos = SINE_TABLE_BITS'(cos_ang[13:0] >> (14 - SINE_TABLE_BITS));
	assign addr_sin = angle_s1[14] ? ROM_AW'(SINE_Q) - ROM_AW'(idx_sin) : ROM_AW'(idx_sin);
	assign addr_cos = cos_ang[14] ? ROM_AW'(SINE_Q) - ROM_AW'(idx_cos) : ROM_AW'(idx_cos);

	fipc_sine_rom u_rom (
		.clk(clk), .en(en), .addr_sin(addr_sin), .addr_cos(addr_cos),
		.data_sin(tab_sin), .data_cos(tab_cos)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s2 <= angle_s1;
			uq_s2 <= uq_s1;
			neg_sin_s2 <= angle_s1[15];
			neg_cos_s2 <= cos_ang[15];
		end
	end

	// stage 3: inverse Park
	logic signed [16:0] sin_v, cos_v;
	logic signed [33:0] alpha_s3, beta_s3;
	logic [15:0] angle_s3;
	assign sin_v = neg_sin_s2 ? -$signed({2'b00, tab_sin}) : $signed({2'b00, tab_sin});
	assign cos_v = neg_cos_s2 ? -$signed({2'b00, tab_cos}) : $signed({2'b00, tab_cos});
	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s3 <= -(34'(uq_s2) * 34'(sin_v));
			beta_s3 <= 34'(uq_s2) * 34'(cos_v);
			angle_s3 <= angle_s2;
		end
	end

	// stage 4: sqrt(3) * beta, floored
	logic signed [51:0] s3b_full;
	logic signed [35:0] s3b_s4;
	logic signed [33:0] alpha_s4;
	logic [15:0] angle_s4;
	assign s3b_full = 52'(beta_s3) * SQRT3_Q16;
	always_ff @(posedge clk) begin
		if (en) begin
			s3b_s4 <= 36'(s3b_full >>> 16);
			alpha_s4 <= alpha_s3;
			angle_s4 <= angle_s3;
		end
	end

	// stage 5: inverse Clarke, offset and clamp
	function automatic logic [30:0] clamp_phase(input logic signed [37:0] v,
		input logic [30:0] lim);
		if (v < 0) return 31'd0;
		if (v > $signed({7'd0, lim})) return lim;
		return v[30:0];
	endfunction

	logic signed [37:0] pa, pb, pc, tb, tc;
	logic [30:0] ua_s5, ub_s5, uc_s5;
	logic [15:0] angle_s5;
	assign tb = 38'(s3b_s4) - 38'(alpha_s4);
	assign tc = -38'(alpha_s4) - 38'(s3b_s4);
	assign pa = 38'(alpha_s4) + hq;
	assign pb = (tb >>> 1) + hq;
	assign pc = (tc >>> 1) + hq;
	always_ff @(posedge clk) begin
		if (en) begin
			ua_s5 <= clamp_phase(pa, full);
			ub_s5 <= clamp_phase(pb, full);
			uc_s5 <= clamp_phase(pc, full);
			angle_s5 <= angle_s4;
		end
	end

	// stage 6: scale by period
	logic [PROD_W-1:0] pra_s6, prb_s6, prc_s6;
	side_t side_s6;
	always_ff @(posedge clk) begin
		if (en) begin
			pra_s6 <= PROD_W'(ua_s5) * PROD_W'(period_q);
			prb_s6 <= PROD_W'(ub_s5) * PROD_W'(period_q);
			prc_s6 <= PROD_W'(uc_s5) * PROD_W'(period_q);
			side_s6 <= '{angle: angle_s5, va: ua_s5[30:15], vb: ub_s5[30:15],
				vc: uc_s5[30:15]};
		end
	end

	// divide by full scale, carry angle and volts alongside
	logic [15:0] qa, qb, qc;
	side_t sd_s [1:DIV_STAGES];

	fipc_duty_div u_div_a (.clk(clk), .en(en), .dividend(pra_s6), .divisor(full),
		.quotient(qa));
	fipc_duty_div u_div_b (.clk(clk), .en(en), .dividend(prb_s6), .divisor(full),
		.quotient(qb));
	fipc_duty_div u_div_c (.clk(clk), .en(en), .dividend(prc_s6), .divisor(full),
		.quotient(qc));

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[1] <= side_s6;
			for (int i = 2; i <= DIV_STAGES; i++) sd_s[i] <= sd_s[i-1];
		end
	end

	// drive result word; zero supply forces zero duty
	assign res_valid = vd_s[DIV_STAGES];
	assign res.electrical_angle = sd_s[DIV_STAGES].angle;
	assign res.phase_a_volts = sd_s[DIV_STAGES].va;
	assign res.phase_b_volts = sd_s[DIV_STAGES].vb;
	assign res.phase_c_volts = sd_s[DIV_STAGES].vc;
	assign res.duty_a = (supply_q == 16'd0) ? 16'd0 : qa;
	assign res.duty_b = (supply_q == 16'd0) ? 16'd0 : qb;
	assign res.duty_c = (supply_q == 16'd0) ? 16'd0 : qc;

endmodule

FILE: rtl/fipc_checker.sv
`timescale 1ns / 1ps
// Port-level checks for foc_inverse_park_clarke_pwm, bound to the top level.
// Depends on fipc_pkg.
module fipc_props import fipc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        cmd_ready,
	input logic        res_valid,
	input logic        res_ready,
	input res_word_t   res
);

	// a waiting result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// intake opens exactly when the output can move
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_ready == (!res_valid || res_ready))
		else $error("cmd_ready does not follow output stall");

	// nothing is offered once reset has been seen
	a_reset: assert property (@(posedge clk) !arst_n |=> !res_valid)
		else $error("result valid during reset");

endmodule

bind foc_inverse_park_clarke_pwm fipc_props u_fipc_props (.*);

FILE: test/fipc_checker.sv
`timescale 1ns / 1ps
// Watches the command and result channels of the inverse Park/Clarke PWM
// block, predicts each result word and compares it. Depends on fipc_pkg.
module fipc_checker import fipc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_ready,
	input  cmd_word_t   cmd,
	input  logic        res_valid,
	input  logic        res_ready,
	input  res_word_t   res,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          result_count
);

	logic [15:0] supply_reg, period_reg, zero_reg;
	logic [6:0] poles_reg;
	logic dir_reg;
	logic [14:0] quarter_wave [0:SINE_Q];
	res_word_t expected_words [$];

	initial begin
		for (int k = 0; k <= SINE_Q; k++) quarter_wave[k] = quarter_sine(k);
	end

	// Taylor series for one quarter-wave entry in Q15
	function automatic logic [14:0] quarter_sine(input int k);
		logic [63:0] x, x2, term, pos, neg, r;
		x = (64'd1686629713 * 64'(k)) >> SINE_TABLE_BITS;
		x2 = (x * x) >> 30;
		term = x;
		pos = 0;
		neg = 0;
		for (int n = 0; n < 10; n++) begin
			if (n & 1) neg += term;
			else pos += term;
			term = ((term * x2) >> 30) / 64'((2 * n + 2) * (2 * n + 3));
		end
		r = (pos > neg) ? pos - neg : 64'd0;
		r = (r + 64'd16384) >> 15;
		if (r > 64'd32767) r = 64'd32767;
		return r[14:0];
	endfunction

	function automatic longint sin_q15(input logic [15:0] a);
		logic [1:0] quad;
		int idx;
		longint v;
		quad = a[15:14];
		idx = int'(a[13:0]) >> (14 - SINE_TABLE_BITS);
		v = quad[0] ? quarter_wave[SINE_Q - idx] : quarter_wave[idx];
		return quad[1] ? -v : v;
	endfunction

	// floor division by 2^sh
	function automatic longint floor_div(input longint v, input int sh);
		return v >>> sh;
	endfunction

	function automatic void clamp_phase(input longint q, input longint full,
			output logic [15:0] volts, output logic [15:0] duty);
		longint u;
		u = q < 0 ? 0 : (q > full ? full : q);
		volts = 16'(u >> 15);
		duty = full == 0 ? 16'd0 : 16'((u * longint'(period_reg)) / full);
	endfunction

	function automatic res_word_t predict_phases(input cmd_word_t c);
		res_word_t w;
		logic [15:0] ang, p;
		longint half, hq, full, uq, alpha, beta, s3b;
		ang = c.rotor_angle;
		if (c.operation == OP_MECHANICAL) begin
			p = 16'(32'(poles_reg) * 32'(ang));
			if (dir_reg) p = -p;
			ang = p - zero_reg;
		end
		half = supply_reg >> 1;
		hq = half * 32768;
		full = longint'(supply_reg) << 15;
		uq = c.torque_voltage;
		if (uq > half) uq = half;
		if (uq < -half) uq = -half;
		alpha = -(uq * sin_q15(ang));
		beta = uq * sin_q15(ang + 16'd16384);
		s3b = floor_div(beta * 113512, 16);
		w.electrical_angle = ang;
		clamp_phase(alpha + hq, full, w.phase_a_volts, w.duty_a);
		clamp_phase(floor_div(s3b - alpha, 1) + hq, full, w.phase_b_volts, w.duty_b);
		clamp_phase(floor_div(-alpha - s3b, 1) + hq, full, w.phase_c_volts, w.duty_c);
		return w;
	endfunction

	assign pending = expected_words.size();

	// track registers, predict on accepted words, compare results
	always @(posedge clk or negedge arst_n) begin
		res_word_t e;
		if (!arst_n) begin
			supply_reg <= 16'd12288;
			period_reg <= 16'd1000;
			poles_reg <= 7'd1;
			dir_reg <= 1'b0;
			zero_reg <= 16'd0;
			fail_count <= 0;
			result_count <= 0;
			expected_words.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SUPPLY: supply_reg <= cfg_data;
					REG_PERIOD: period_reg <= cfg_data;
					REG_POLES: poles_reg <= cfg_data[6:0];
					REG_DIR: dir_reg <= cfg_data[0];
					REG_ZERO: zero_reg <= cfg_data;
					default: ;
				endcase
			end
			if (cmd_valid && cmd_ready) expected_words.push_back(predict_phases(cmd));
			if (res_valid && res_ready) begin
				result_count <= result_count + 1;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, res);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_words.pop_front();
					if (res !== e) begin
						$display("%0t: mismatch expected %h actual %h", $time, e, res);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

FILE: test/tb_foc_inverse_park_clarke_pwm.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the inverse Park/Clarke PWM block; checking is in
// fipc_checker. Depends on fipc_pkg and the block under test.
module tb_foc_inverse_park_clarke_pwm;
	import fipc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_word_t cmd = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	res_word_t res;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_SUPPLY;
	logic [15:0] cfg_data = '0;
	int fail_count, pending, result_count;
	int cycle_count = 0;
	bit calm = 1'b0;
	bit hold_sink = 1'b0;

	always #6 clk = ~clk;

	foc_inverse_park_clarke_pwm u_dut (.*);

	fipc_checker u_check (.*);

	// bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, a long hold-off on request
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				res_ready <= 1'b0;
				repeat (200) @(negedge clk);
				hold_sink = 1'b0;
			end
			if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 6);
				res_ready <= 1'b0;
				repeat (n) @(negedge clk);
			end
			res_ready <= 1'b1;
		end
	end

	// send one command word; may insert an idle burst first; valid stays up
	// until the next word or an explicit drop
	task automatic send_word(input logic op, input logic [15:0] uq, input logic [15:0] ang);
		if (!calm && $urandom_range(0, 5) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= '{operation: op, torque_voltage: uq, rotor_angle: ang};
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid, drain results, then let the pipeline empty before touching registers
	task automatic drain_pipe();
		cmd_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic random_words(input int count);
		logic [15:0] uq;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 3))
				0: uq = 16'($urandom);
				1: uq = 16'($urandom_range(0, 8191));
				2: uq = -16'($urandom_range(0, 8191));
				default: uq = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			endcase
			send_word(1'($urandom), uq, 16'($urandom));
		end
	endtask

	initial begin
		logic [15:0] corner_angles [6];
		corner_angles = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'hffff, 16'h2aaa};
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset registers, extremes of every field and both operations
		foreach (corner_angles[i]) begin
			send_word(OP_ELECTRICAL, 16'h7fff, corner_angles[i]);
			send_word(OP_MECHANICAL, 16'h8000, corner_angles[i]);
		end
		send_word(OP_ELECTRICAL, 16'h0000, 16'h1234);
		send_word(OP_ELECTRICAL, 16'hffff, 16'h5555);
		drain_pipe();

		// odd supply, zero pole pairs, reverse direction
		write_reg(REG_SUPPLY, 16'd12289);
		write_reg(REG_POLES, 16'd0);
		write_reg(REG_DIR, 16'd1);
		write_reg(REG_ZERO, 16'h1000);
		send_word(OP_MECHANICAL, 16'h0100, 16'h7777);
		send_word(OP_ELECTRICAL, 16'hff00, 16'h3000);
		drain_pipe();
		// zero supply
		write_reg(REG_SUPPLY, 16'd0);
		send_word(OP_ELECTRICAL, 16'h1000, 16'h1000);
		send_word(OP_MECHANICAL, 16'h8000, 16'h9000);
		drain_pipe();

		// random phases over several register settings
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin write_reg(REG_SUPPLY, 16'd65535); write_reg(REG_PERIOD, 16'd65535);
					write_reg(REG_POLES, 16'd64); write_reg(REG_DIR, 16'd0);
					write_reg(REG_ZERO, 16'hffff); end
				1: begin write_reg(REG_SUPPLY, 16'd1); write_reg(REG_PERIOD, 16'd1);
					write_reg(REG_POLES, 16'd1); write_reg(REG_ZERO, 16'd0); end
				2: begin write_reg(REG_POLES, 16'd127); write_reg(REG_SUPPLY, 16'd24576); end
				default: begin
					write_reg(REG_SUPPLY, 16'($urandom_range(1, 65535)));
					write_reg(REG_PERIOD, 16'($urandom_range(1, 65535)));
					write_reg(REG_POLES, 16'($urandom_range(1, 64)));
					write_reg(REG_DIR, 16'($urandom_range(0, 1)));
					write_reg(REG_ZERO, 16'($urandom));
				end
			endcase
			if (ph == 4) hold_sink = 1'b1;
			if (ph == 7) calm = 1'b1;
			random_words(140);
			drain_pipe();
		end

		$display("Covered %0d result words over directed corners and eight register settings,",
			result_count);
		$display("including zero and odd supply, extreme periods and pole counts, both directions.");
		if (fail_count == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule

FILE: sim.f
rtl/fipc_pkg.sv
rtl/fipc_sine_rom.sv
rtl/fipc_duty_div.sv
rtl/foc_inverse_park_clarke_pwm.sv
rtl/fipc_checker.sv
test/fipc_checker.sv
test/tb_foc_inverse_park_clarke_pwm.sv
